// ===== hdl/lzbr_pkg.sv =====
`default_nettype none
package lzbr_pkg;

	localparam int KIND_W  = 2;
	localparam int ERR_W   = 2;
	localparam int COUNT_W = 24;
	localparam int RUN_W   = 13;

	localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

	localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] ERR_BAD_DIST = 2'd1;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;
	localparam logic [ERR_W-1:0] ERR_BUSY     = 2'd3;

	localparam logic [COUNT_W-1:0] CAP_RESET  = 24'hFF_FFFF;
	localparam logic [RUN_W-1:0]   FILL_BIAS  = 13'd14;
	localparam logic [RUN_W-1:0]   LBYTE_BIAS = 13'd14;
	localparam logic [RUN_W-1:0]   LCODE_BIAS = 13'd6;
	localparam logic [RUN_W-1:0]   LEN_MIN    = 13'd2;

	// result beat waiting in stage 1
	typedef struct packed {
		logic               valid;
		logic [KIND_W-1:0]  kind;
		logic [7:0]         data;
		logic [ERR_W-1:0]   err;
		logic [COUNT_W-1:0] total;
		logic               copy;   // data comes from history read
		logic               we;     // byte goes into history
	} res_t;

endpackage
`default_nettype wire

// ===== hdl/lz_bitflag_rle_decompressor_top.sv =====
`default_nettype none
// LZ bit-flag decompressor with RLE fills. Input beats carry s_tuser=0 to feed one
// compressed byte (s_tdata) or s_tuser=1 to pull the next byte of a pending copy or
// fill. Each accepted beat gives at most one output beat: a data byte, end of stream
// or an error, with the running output byte count. One input beat per clock is taken
// and one output beat per clock is given while m_tready does not hold the output;
// every beat passes through two register stages (control update and history
// read, then the output register), so a result reaches m_tvalid when stage 1
// drains into the output register. The history window is a single-port-write,
// single-port-read memory of 2**clog2(WINDOW_DEPTH) bytes with a registered read; a
// copy reading the byte written in the same cycle is served by forwarding. The user must
// write out_capacity through cfg_we/cfg_data only while the block is idle (unenforced).
module lz_bitflag_rle_decompressor_top #(
	parameter int WINDOW_DEPTH = 8192
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tuser,   // [0] cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,   // [7:0] data_byte, [9:8] error_code,
	                                    // [33:10] total_out, [39:34] zero
	output logic      [1:0]  m_tuser,   // [1:0] kind
	input  wire logic        cfg_we,
	input  wire logic [23:0] cfg_data   // out_capacity
);
	import lzbr_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);

	res_t          res_s1;
	logic [AW-1:0] wr_addr_s1, rd_addr;
	logic          rd_en, acc, adv1, wr_en;
	logic [7:0]    rd_data, wr_data, fwd_data_s1;
	logic          fwd_s1;

	// stage 1 drains into the output register when that is free or being taken
	assign adv1     = res_s1.valid && (!m_tvalid || m_tready);
	assign s_tready = !res_s1.valid || adv1;
	assign acc      = s_tvalid && s_tready;
	assign wr_en    = adv1 && res_s1.we;
	assign wr_data  = !res_s1.copy ? res_s1.data : (fwd_s1 ? fwd_data_s1 : rd_data);

	lzbr_ctrl #(.AW(AW)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.cmd        (s_tuser),
		.in_byte    (s_tdata),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.take_s1    (adv1),
		.res_s1     (res_s1),
		.wr_addr_s1 (wr_addr_s1),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr)
	);

	lzbr_hist #(.AW(AW)) u_hist (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr_s1),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// read and write hitting the same entry on one edge: keep the new byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1      <= 1'b0;
			fwd_data_s1 <= '0;
		end else if (acc) begin
			fwd_s1      <= wr_en && (wr_addr_s1 == rd_addr);
			fwd_data_s1 <= wr_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= '0;
		end else if (adv1) begin
			m_tvalid <= 1'b1;
			m_tdata  <= {6'd0, res_s1.total, res_s1.err, wr_data};
			m_tuser  <= res_s1.kind;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_s1.valid && !adv1 |=> res_s1.valid)
		else $error("stage 1 beat lost under stall");
	a_copy_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_s1.valid && res_s1.copy |-> res_s1.kind == KIND_DATA && res_s1.we)
		else $error("history copy without data write");
	a_we_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_s1.valid && res_s1.we |-> res_s1.kind == KIND_DATA)
		else $error("history write from non-data beat");
endmodule
`default_nettype wire

// ===== hdl/lzbr_hist.sv =====
`default_nettype none
module lzbr_hist #(
	parameter int AW = 13
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);
	logic [7:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ===== hdl/lzbr_ctrl.sv =====
`default_nettype none
module lzbr_ctrl #(
	parameter int AW = 13
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           acc,
	input  wire logic           cmd,
	input  wire logic [7:0]     in_byte,
	input  wire logic           cfg_we,
	input  wire logic [23:0]    cfg_data,
	input  wire logic           take_s1,
	output lzbr_pkg::res_t      res_s1,
	output logic      [AW-1:0]  wr_addr_s1,
	output logic                rd_en,
	output logic      [AW-1:0]  rd_addr
);
	import lzbr_pkg::*;

	typedef enum logic [4:0] {
		PH_HDR    = 5'd0,  PH_FLAG0  = 5'd1,  PH_CMD   = 5'd2,  PH_DSEL  = 5'd3,
		PH_DSHORT = 5'd4,  PH_DHI    = 5'd5,  PH_DLO   = 5'd6,  PH_FEXT  = 5'd7,
		PH_FCNT   = 5'd8,  PH_FCNTLO = 5'd9,  PH_FVAL  = 5'd10, PH_LEN0  = 5'd11,
		PH_LEN1   = 5'd12, PH_LEN2   = 5'd13, PH_LEN3  = 5'd14, PH_LEN4  = 5'd15,
		PH_LCODE  = 5'd16, PH_LBYTE  = 5'd17, PH_LIT   = 5'd18, PH_CONT  = 5'd19,
		PH_HALT   = 5'd20
	} ph_t;

	typedef enum logic [1:0] {
		RF_NONE = 2'd0, RF_LO = 2'd1, RF_HI = 2'd2
	} rf_t;

	typedef struct packed {
		ph_t              ph;
		logic [15:0]      fw;
		logic [4:0]       bl;
		logic [RUN_W-1:0] ca;
		logic [2:0]       cl;
		logic             fwid;
		logic [RUN_W-1:0] run;
		logic             isfill;
		rf_t              refill;
		logic             fail;
	} adv_t;

	function automatic logic wants_bit(ph_t p);
		return p == PH_CMD || p == PH_DSEL || p == PH_DHI || p == PH_FEXT ||
			p == PH_FCNT || p == PH_LEN0 || p == PH_LEN1 || p == PH_LEN2 ||
			p == PH_LEN3 || p == PH_LEN4 || p == PH_LCODE;
	endfunction

	// walk flag bits until a byte is needed, a run starts, a bad distance halts or flags run dry
	function automatic adv_t advance(adv_t a, logic bad);
		adv_t             r;
		logic             stop;
		logic             b;
		logic             go;
		logic [RUN_W-1:0] len;
		r    = a;
		stop = 1'b0;
		for (int i = 0; i < 8; i++) begin
			go  = 1'b0;
			len = '0;
			if (!stop) begin
				if (r.run != '0 || r.refill != RF_NONE || !wants_bit(r.ph)) begin
					stop = 1'b1;
				end else if (r.bl == 5'd0) begin
					r.refill = RF_LO;
					stop     = 1'b1;
				end else begin
					b    = r.fw[0];
					r.fw = {1'b0, r.fw[15:1]};
					r.bl = r.bl - 5'd1;
					unique case (r.ph)
						PH_CMD:  r.ph = b ? PH_DSEL : PH_LIT;
						PH_DSEL: begin
							if (b) begin
								r.ca = '0; r.cl = 3'd5; r.ph = PH_DHI;
							end else begin
								r.ph = PH_DSHORT;
							end
						end
						PH_DHI: begin
							r.ca = {r.ca[RUN_W-2:0], b};
							r.cl = r.cl - 3'd1;
							if (r.cl == 3'd0) r.ph = PH_DLO;
						end
						PH_FEXT: begin
							r.fwid = b; r.ca = '0; r.cl = 3'd4; r.ph = PH_FCNT;
						end
						PH_FCNT: begin
							r.ca = {r.ca[RUN_W-2:0], b};
							r.cl = r.cl - 3'd1;
							if (r.cl == 3'd0) r.ph = r.fwid ? PH_FCNTLO : PH_FVAL;
						end
						PH_LEN4: begin
							if (b) begin
								r.ca = '0; r.cl = 3'd3; r.ph = PH_LCODE;
							end else begin
								r.ph = PH_LBYTE;
							end
						end
						PH_LCODE: begin
							r.ca = {r.ca[RUN_W-2:0], b};
							r.cl = r.cl - 3'd1;
							if (r.cl == 3'd0) begin
								go  = 1'b1;
								len = r.ca + LCODE_BIAS;
							end
						end
						default: begin // unary length bits
							if (b) begin
								go  = 1'b1;
								len = RUN_W'(5'(r.ph) - 5'(PH_LEN0)) + LEN_MIN;
							end else begin
								r.ph = ph_t'(5'(r.ph) + 5'd1);
							end
						end
					endcase
					if (go) begin
						if (bad) begin
							r.ph = PH_HALT; r.fail = 1'b1; stop = 1'b1;
						end else begin
							r.run = len; r.isfill = 1'b0; r.ph = PH_CMD;
						end
					end
				end
			end
		end
		return r;
	endfunction

	adv_t              st_q, st_n, st_a;
	logic [1:0]        hdr_q, hdr_n;
	logic [RUN_W-1:0]  cd_q, cd_n;
	logic [7:0]        fv_q, fv_n;
	logic [23:0]       oc_q, oc_n;
	logic              fin_q, fin_n;
	logic [23:0]       cap_q;
	res_t              res_n;
	logic              do_adv, use_adv, bad;
	logic [RUN_W-1:0]  dlo;
	logic              full;

	assign dlo     = {st_q.ca[4:0], in_byte};
	assign full    = oc_q >= cap_q;
	assign rd_addr = AW'(oc_q - {11'd0, cd_q});

	always_comb begin
		st_n    = st_q;
		st_n.fail = 1'b0;
		hdr_n   = hdr_q;
		cd_n    = cd_q;
		fv_n    = fv_q;
		oc_n    = oc_q;
		fin_n   = fin_q;
		res_n   = '0;
		rd_en   = 1'b0;
		do_adv  = 1'b0;
		use_adv = 1'b0;
		if (fin_q || st_q.ph == PH_HALT) begin
			// dead until reset
		end else if (!cmd) begin
			if (st_q.run != '0) begin
				res_n = '{valid: 1'b1, kind: KIND_ERROR, err: ERR_BUSY, default: '0};
			end else if (st_q.refill == RF_LO) begin
				st_n.fw     = {8'd0, in_byte};
				st_n.refill = RF_HI;
			end else if (st_q.refill == RF_HI) begin
				st_n.fw     = {in_byte, st_q.fw[7:0]};
				st_n.bl     = 5'd16;
				st_n.refill = RF_NONE;
				do_adv = 1'b1; use_adv = 1'b1;
			end else begin
				unique case (st_q.ph)
					PH_HDR: begin
						if (hdr_q <= 2'd1) st_n.ph = PH_FLAG0;
						else hdr_n = hdr_q - 2'd1;
					end
					PH_FLAG0: begin
						st_n.fw = {8'd0, in_byte}; st_n.bl = 5'd8; st_n.ph = PH_CMD;
						do_adv = 1'b1; use_adv = 1'b1;
					end
					PH_LIT: begin
						if (full) begin
							st_n.ph = PH_HALT;
							res_n = '{valid: 1'b1, kind: KIND_ERROR, err: ERR_OVERFLOW,
								default: '0};
						end else begin
							oc_n    = oc_q + 24'd1;
							st_n.ph = PH_CMD;
							do_adv  = 1'b1;
							res_n = '{valid: 1'b1, kind: KIND_DATA, data: in_byte, we: 1'b1,
								default: '0};
						end
					end
					PH_DSHORT: begin
						cd_n = {5'd0, in_byte}; st_n.ph = PH_LEN0;
						do_adv = 1'b1; use_adv = 1'b1;
					end
					PH_DLO: begin
						if (dlo == '0) begin
							st_n.ph = PH_CONT;
						end else if (dlo == 13'd1) begin
							st_n.ph = PH_FEXT;
							do_adv = 1'b1; use_adv = 1'b1;
						end else begin
							cd_n = dlo; st_n.ph = PH_LEN0;
							do_adv = 1'b1; use_adv = 1'b1;
						end
					end
					PH_FCNTLO: begin
						st_n.ca = dlo; st_n.ph = PH_FVAL;
					end
					PH_FVAL: begin
						fv_n        = in_byte;
						st_n.run    = st_q.ca + FILL_BIAS;
						st_n.isfill = 1'b1;
						st_n.ph     = PH_CMD;
					end
					PH_LBYTE: begin
						if (cd_q == '0 || {11'd0, cd_q} > oc_q) begin
							st_n.ph = PH_HALT;
							res_n = '{valid: 1'b1, kind: KIND_ERROR, err: ERR_BAD_DIST,
								default: '0};
						end else begin
							st_n.run    = {5'd0, in_byte} + LBYTE_BIAS;
							st_n.isfill = 1'b0;
							st_n.ph     = PH_CMD;
						end
					end
					PH_CONT: begin
						if (in_byte == 8'd0) begin
							fin_n = 1'b1;
							res_n = '{valid: 1'b1, kind: KIND_END, default: '0};
						end else begin
							hdr_n = 2'd3; st_n.ph = PH_HDR;
						end
					end
					default: ;
				endcase
			end
		end else if (st_q.run != '0) begin
			if (full) begin
				st_n.ph = PH_HALT;
				res_n = '{valid: 1'b1, kind: KIND_ERROR, err: ERR_OVERFLOW, default: '0};
			end else begin
				// read only on a taken beat so a waiting copy keeps its byte
				rd_en    = acc && !st_q.isfill;
				oc_n     = oc_q + 24'd1;
				st_n.run = st_q.run - 13'd1;
				do_adv   = st_n.run == '0;
				res_n = '{valid: 1'b1, kind: KIND_DATA, data: fv_q, copy: !st_q.isfill,
					we: 1'b1, default: '0};
			end
		end
		bad  = cd_n == '0 || {11'd0, cd_n} > oc_n;
		st_a = advance(st_n, bad);
		if (do_adv) begin
			st_n = st_a;
			if (use_adv && st_a.fail) begin
				res_n = '{valid: 1'b1, kind: KIND_ERROR, err: ERR_BAD_DIST, default: '0};
			end
		end
		res_n.total = oc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= '{ph: PH_HDR, refill: RF_NONE, default: '0};
			hdr_q      <= 2'd3;
			cd_q       <= '0;
			fv_q       <= '0;
			oc_q       <= '0;
			fin_q      <= 1'b0;
			cap_q      <= CAP_RESET;
			res_s1     <= '0;
			wr_addr_s1 <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (acc) begin
				st_q       <= st_n;
				hdr_q      <= hdr_n;
				cd_q       <= cd_n;
				fv_q       <= fv_n;
				oc_q       <= oc_n;
				fin_q      <= fin_n;
				res_s1     <= res_n;
				wr_addr_s1 <= oc_q[AW-1:0];
			end else if (take_s1) begin
				res_s1.valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire
